@@ rtl/sfd_pkg.sv @@
// Shared types and constants for the SLIP frame decoder.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package sfd_pkg;

    // SLIP special characters
    localparam logic [7:0] SLIP_END  = 8'hC0;
    localparam logic [7:0] SLIP_ESC  = 8'hDB;
    localparam logic [7:0] SLIP_TEND = 8'hDC;
    localparam logic [7:0] SLIP_TESC = 8'hDD;

    localparam int unsigned LEN_W = 12;
    localparam int unsigned CNT_W = 32;

    localparam logic [LEN_W-1:0] MAX_FRAME_LEN_RESET = 12'd1006;

    // Request codes
    localparam logic REQ_BYTE   = 1'b0;
    localparam logic REQ_REOPEN = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] line_byte;
    } sfd_in_t;

    typedef struct packed {
        logic             is_data;
        logic             is_frame_end;
        logic             restarted;
        logic [7:0]       out_byte;
        logic [LEN_W-1:0] frame_len;
        logic [CNT_W-1:0] good_frames;
        logic [CNT_W-1:0] error_count;
    } sfd_out_t;

endpackage

`default_nettype wire

@@ rtl/slip_frame_decoder_top.sv @@
// SLIP receive decoder: unstuffs line words into payload words and frame ends.
// Depends on sfd_pkg.
`default_nettype none

// Usage: each input word is a received line byte or a reopen request. The
// block takes one word per cycle while the output is not stalled. An
// accepted word sits in the input register, then a single pass of logic
// updates the decoder state (escape flag, frame length, frame and error
// counters) and loads the output register, where the result shows until
// it is taken at an edge with out_ready high. Sustained rate is one word
// per cycle while out_ready stays high; state updates loop through the
// decoder state registers. END on an empty frame, ESC and reopen give no
// result. The output register may hold a result while the next word is
// taken; a stalled output stalls the input register, which in turn drops
// in_ready. max_frame_len is written through the cfg channel, which is
// always ready and should only be used while the block is idle.
module slip_frame_decoder_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire sfd_pkg::sfd_in_t  in_data,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      sfd_pkg::sfd_out_t out_data,
    input  wire logic              cfg_valid,
    output      logic              cfg_ready,
    input  wire logic [11:0]       cfg_data
);
    import sfd_pkg::*;

    // configuration
    logic [LEN_W-1:0] max_len_reg;

    // input register
    logic    s1_valid_reg;
    sfd_in_t s1_item_reg;

    // decoder state
    logic             esc_reg,   esc_next;
    logic [LEN_W-1:0] len_reg,   len_next;
    logic [CNT_W-1:0] frames_reg, frames_next;
    logic [CNT_W-1:0] errors_reg, errors_next;

    // output register
    logic     out_valid_reg, out_valid_next;
    sfd_out_t out_data_reg,  out_data_next;

    logic       advance;
    logic       has_result;
    logic [7:0] mapped_byte;

    // Input register moves on whenever the output register is free or drains.
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Undo the escape: transposed END/ESC map back, anything else passes.
    always_comb
    begin
        mapped_byte = s1_item_reg.line_byte;
        if (esc_reg)
        begin
            case (s1_item_reg.line_byte)
                SLIP_TEND: mapped_byte = SLIP_END;
                SLIP_TESC: mapped_byte = SLIP_ESC;
                default:   mapped_byte = s1_item_reg.line_byte;
            endcase
        end
    end

    always_comb
    begin
        esc_next      = esc_reg;
        len_next      = len_reg;
        frames_next   = frames_reg;
        errors_next   = errors_reg;
        has_result    = 1'b0;
        out_data_next = '0;

        if (s1_item_reg.req_type == REQ_REOPEN)
        begin
            // drop partial frame, counters survive
            esc_next = 1'b0;
            len_next = '0;
        end
        else if (s1_item_reg.line_byte == SLIP_END)
        begin
            // empty frames are silently skipped; escape flag untouched
            if (len_reg != '0)
            begin
                frames_next                = frames_reg + 1'b1;
                len_next                   = '0;
                has_result                 = 1'b1;
                out_data_next.is_frame_end = 1'b1;
            end
        end
        else if (s1_item_reg.line_byte == SLIP_ESC)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            esc_next   = 1'b0;
            has_result = 1'b1;
            out_data_next.is_data  = 1'b1;
            out_data_next.out_byte = mapped_byte;
            if (len_reg >= max_len_reg)
            begin
                // overflow: restart the frame with this word
                errors_next             = errors_reg + 1'b1;
                len_next                = LEN_W'(1);
                out_data_next.restarted = 1'b1;
            end
            else
            begin
                len_next = len_reg + 1'b1;
            end
        end

        out_data_next.frame_len   = len_next;
        out_data_next.good_frames = frames_next;
        out_data_next.error_count = errors_next;
    end

    always_comb
    begin
        if (advance)
            out_valid_next = has_result;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_FRAME_LEN_RESET;
            s1_valid_reg  <= 1'b0;
            esc_reg       <= 1'b0;
            len_reg       <= '0;
            frames_reg    <= '0;
            errors_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_len_reg <= cfg_data;
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
            begin
                esc_reg    <= esc_next;
                len_reg    <= len_next;
                frames_reg <= frames_next;
                errors_reg <= errors_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_item_reg <= in_data;
        if (advance && has_result)
            out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

@@ rtl/sfd_checker.sv @@
// Port-level checks for the SLIP frame decoder, bound to the top level.
// Depends on sfd_pkg and slip_frame_decoder_top.
`default_nettype none

module sfd_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire sfd_pkg::sfd_out_t out_data
);
    import sfd_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // every result is either a data word or a frame end
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot({out_data.is_data, out_data.is_frame_end}))
        else $error("result kind not one-hot");

    // frame end carries a cleared frame and no data
    a_fend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_frame_end |->
            out_data.frame_len == '0 && !out_data.restarted
            && out_data.out_byte == 8'h00)
        else $error("frame end with stale payload");

    // a data word always leaves a non-empty frame; a restart leaves one word
    a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_data |->
            out_data.frame_len != '0
            && (!out_data.restarted || out_data.frame_len == LEN_W'(1)))
        else $error("bad frame length on data word");

    // restart flag only on data words
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.restarted |-> out_data.is_data)
        else $error("restart flagged on frame end");

endmodule

bind slip_frame_decoder_top sfd_checker u_sfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

@@ tb/tb_slip_frame_decoder_top.sv @@
// Self-checking bench for slip_frame_decoder_top: random-paced line words in, decoded words out.
// Depends on sfd_pkg and the decoder RTL; needs no other files.
`default_nettype none

module tb_slip_frame_decoder_top;
    import sfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_WORDS = 230;
    localparam int unsigned DRAIN_CYCLES = 4;   // word in flight: input reg + output reg
    localparam int unsigned TAIL_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_ready;
    sfd_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    sfd_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [11:0] cfg_data = '0;

    slip_frame_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Line words waiting to be driven, and decoder words predicted but not yet seen.
    sfd_in_t line_q[$];
    sfd_out_t decoded_q[$];

    // Shadow copy of the decoder state.
    logic [LEN_W-1:0] max_len = MAX_FRAME_LEN_RESET;
    logic esc_armed = 1'b0;
    logic [LEN_W-1:0] frame_bytes = '0;
    logic [CNT_W-1:0] frames_done = '0;
    logic [CNT_W-1:0] overflow_cnt = '0;

    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned phase_words = 0;

    // Handshake flags: set at the rising edge, read by the drivers at the falling edge.
    bit in_took = 1'b0;
    bit out_took = 1'b0;

    int unsigned in_gap = 0;
    int unsigned out_stall = 0;
    bit in_calm = 1'b0;
    bit out_calm = 1'b0;
    logic drive_valid;

    task automatic report_mismatch(string msg);
        $display("ERROR @%0d: %s", cycles, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // Decode one accepted line word; push the word it produces, if any.
    task automatic decode_word(sfd_in_t w);
        sfd_out_t r;
        logic [7:0] b;
        r = '0;
        b = w.line_byte;
        if (w.req_type == REQ_REOPEN)
        begin
            // reopen drops the partial frame, counters survive
            frame_bytes = '0;
            esc_armed = 1'b0;
        end
        else if (b == SLIP_END)
        begin
            // empty frames vanish; escape flag deliberately left alone
            if (frame_bytes != 0)
            begin
                frames_done = frames_done + 1'b1;
                frame_bytes = '0;
                r.is_frame_end = 1'b1;
                r.good_frames = frames_done;
                r.error_count = overflow_cnt;
                decoded_q.push_back(r);
            end
        end
        else if (b == SLIP_ESC)
        begin
            esc_armed = 1'b1;
        end
        else
        begin
            if (esc_armed)
            begin
                esc_armed = 1'b0;
                if (b == SLIP_TEND)
                    b = SLIP_END;
                else if (b == SLIP_TESC)
                    b = SLIP_ESC;
            end
            // full frame: count an error and start over with this byte
            if (frame_bytes >= max_len)
            begin
                overflow_cnt = overflow_cnt + 1'b1;
                frame_bytes = '0;
                r.restarted = 1'b1;
            end
            frame_bytes = frame_bytes + 1'b1;
            r.is_data = 1'b1;
            r.out_byte = b;
            r.frame_len = frame_bytes;
            r.good_frames = frames_done;
            r.error_count = overflow_cnt;
            decoded_q.push_back(r);
        end
    endtask

    function automatic int unsigned draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // Byte source biased toward the SLIP specials so escapes show up often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return SLIP_END;
            1: return SLIP_ESC;
            2: return SLIP_TEND;
            3: return SLIP_TESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_word(logic req, logic [7:0] b);
        sfd_in_t w;
        w.req_type = req;
        w.line_byte = b;
        line_q.push_back(w);
        phase_words++;
    endtask

    // Stuffed frame with END at the tail. A damaged frame gets a reopen,
    // an ESC+END pair, or a bare ESC spliced into its middle.
    task automatic queue_frame(int unsigned len, bit damaged);
        logic [7:0] b;
        int unsigned cut;
        cut = len / 2;
        for (int unsigned i = 0; i < len; i++)
        begin
            if (damaged && i == cut)
            begin
                case ($urandom_range(0, 2))
                    0: queue_word(REQ_REOPEN, 8'($urandom_range(0, 255)));
                    1:
                    begin
                        queue_word(REQ_BYTE, SLIP_ESC);
                        queue_word(REQ_BYTE, SLIP_END);
                    end
                    default: queue_word(REQ_BYTE, SLIP_ESC);
                endcase
            end
            b = pick_byte();
            if (b == SLIP_END)
            begin
                queue_word(REQ_BYTE, SLIP_ESC);
                queue_word(REQ_BYTE, SLIP_TEND);
            end
            else if (b == SLIP_ESC)
            begin
                queue_word(REQ_BYTE, SLIP_ESC);
                queue_word(REQ_BYTE, SLIP_TESC);
            end
            else
            begin
                queue_word(REQ_BYTE, b);
            end
        end
        queue_word(REQ_BYTE, SLIP_END);
    endtask

    // Unstuffed line garbage with the odd reopen.
    task automatic queue_noise();
        int unsigned n;
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            if ($urandom_range(0, 15) == 0)
                queue_word(REQ_REOPEN, 8'($urandom_range(0, 255)));
            else
                queue_word(REQ_BYTE, pick_byte());
        end
    endtask

    // Idle means: nothing left to drive, nothing predicted outstanding, and
    // enough cycles for a word that yields no result to leave the pipeline.
    // Sampled at the rising edge, where the driver's queue and in_valid agree.
    task automatic wait_idle();
        while (line_q.size() != 0 || in_valid || decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_max_len(logic [11:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Line-side driver: one word at a time, random gap after each acceptance.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            drive_valid = in_valid;
            if (in_valid && in_took)
            begin
                drive_valid = 1'b0;
                in_gap = draw_wait(in_calm);
            end
            if (!drive_valid)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (line_q.size() > 0)
                begin
                    in_data <= line_q.pop_front();
                    drive_valid = 1'b1;
                end
            end
            in_valid <= drive_valid;
            // occasionally flip into or out of a no-gap stretch
            if ($urandom_range(0, 63) == 0)
                in_calm = !in_calm;
        end
    end

    // Result-side back-pressure: random stall after each accepted word.
    always @(negedge clk)
    begin
        if (out_took)
            out_stall = draw_wait(out_calm);
        if (out_stall > 0)
        begin
            out_ready <= 1'b0;
            out_stall--;
        end
        else
        begin
            out_ready <= 1'b1;
        end
        if ($urandom_range(0, 63) == 0)
            out_calm = !out_calm;
    end

    // Monitor: register writes and input words update the shadow state first,
    // then any accepted result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        cycles++;
        in_took = rst_n && in_valid && in_ready;
        out_took = rst_n && out_valid && out_ready;
        if (rst_n && cfg_valid && cfg_ready)
            max_len = cfg_data;
        if (in_took)
            decode_word(in_data);
        if (out_took)
        begin
            if (decoded_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result 0x%0h", out_data));
            end
            else
            begin
                sfd_out_t want;
                want = decoded_q.pop_front();
                check_field("is_data", 32'(out_data.is_data), 32'(want.is_data));
                check_field("is_frame_end", 32'(out_data.is_frame_end),
                    32'(want.is_frame_end));
                check_field("restarted", 32'(out_data.restarted), 32'(want.restarted));
                check_field("out_byte", 32'(out_data.out_byte), 32'(want.out_byte));
                check_field("frame_len", 32'(out_data.frame_len), 32'(want.frame_len));
                check_field("good_frames", out_data.good_frames, want.good_frames);
                check_field("error_count", out_data.error_count, want.error_count);
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus: directed words at the reset length and at lengths one and zero, then
    // random phases, each at its own max_frame_len, written only while the decoder is idle.
    initial
    begin
        int unsigned len_settings[8];
        int unsigned lim;
        int unsigned pick;
        len_settings = '{2, 1, 4095, 0, 0, 9, 1006, 4095};
        len_settings[4] = $urandom_range(3, 40);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty END, reopen on nothing, byte extremes, both escapes,
        // escape of an ordinary byte, END inside an escape (flag survives),
        // reopen inside an escape (flag cleared), empty END after a reopen.
        queue_word(REQ_BYTE, SLIP_END);
        queue_word(REQ_REOPEN, 8'hFF);
        queue_word(REQ_BYTE, 8'h00);
        queue_word(REQ_BYTE, 8'hFF);
        queue_word(REQ_BYTE, SLIP_ESC);
        queue_word(REQ_BYTE, SLIP_TEND);
        queue_word(REQ_BYTE, SLIP_ESC);
        queue_word(REQ_BYTE, SLIP_TESC);
        queue_word(REQ_BYTE, SLIP_ESC);
        queue_word(REQ_BYTE, 8'h41);
        queue_word(REQ_BYTE, SLIP_ESC);
        queue_word(REQ_BYTE, SLIP_END);
        queue_word(REQ_BYTE, SLIP_TEND);
        queue_word(REQ_BYTE, SLIP_END);
        queue_word(REQ_BYTE, SLIP_ESC);
        queue_word(REQ_REOPEN, 8'h00);
        queue_word(REQ_BYTE, SLIP_TEND);
        queue_word(REQ_REOPEN, 8'h5A);
        queue_word(REQ_BYTE, SLIP_END);
        queue_word(REQ_BYTE, SLIP_TESC);
        queue_word(REQ_BYTE, SLIP_END);
        wait_idle();

        // Length one: every byte past the first restarts the frame.
        write_max_len(12'd1);
        queue_word(REQ_BYTE, 8'h55);
        queue_word(REQ_BYTE, 8'hAA);
        queue_word(REQ_BYTE, SLIP_END);
        wait_idle();

        // Length zero: even the first byte counts as an overflow.
        write_max_len(12'd0);
        queue_word(REQ_BYTE, 8'h01);
        queue_word(REQ_BYTE, 8'h02);
        queue_word(REQ_BYTE, SLIP_END);
        wait_idle();

        // Random phases: mostly well-formed frames sized up to just past small
        // limits for overflow restarts, plus damaged frames, noise and reopens.
        foreach (len_settings[p])
        begin
            write_max_len(12'(len_settings[p]));
            lim = (len_settings[p] < 24) ? len_settings[p] + 2 : 24;
            phase_words = 0;
            while (phase_words < PHASE_WORDS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    queue_frame($urandom_range(0, lim), 1'b0);
                else if (pick < 85)
                    queue_frame($urandom_range(0, lim), 1'b1);
                else if (pick < 97)
                    queue_noise();
                else
                    queue_word(REQ_REOPEN, 8'($urandom_range(0, 255)));
            end
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && decoded_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
